// File: hw/rtl/itb_pkg.sv
// itb_pkg: shared constants, opcodes and types for the interval timer bank
// used by itb_step_unit and interval_timer_bank_unit; no dependencies
package itb_pkg;

  localparam int TIMER_COUNT = 8;
  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_QUERY = 2'd3
  } itb_op_e;

  // outcome of applying pending ticks to one timer
  typedef struct packed {
    logic             expire;
    logic [CNT_W-1:0] remaining;
  } itb_step_t;

endpackage

// File: hw/rtl/itb_step_unit.sv
// itb_step_unit: shared subtract-compare unit that ages one timer by the
// pending tick count; depends on itb_pkg
module itb_step_unit import itb_pkg::*; (
  input  logic [CNT_W-1:0] remaining_i,
  input  logic [CNT_W-1:0] reload_i,
  input  logic [CNT_W-1:0] delta_i,
  output itb_step_t        step_o
);

  logic [CNT_W:0] diff;
  logic           at_or_below;
  logic           running;

  // one wide subtract gives both the new count and the compare
  assign diff        = {1'b0, remaining_i} - {1'b0, delta_i};
  assign at_or_below = diff[CNT_W] || (diff[CNT_W-1:0] == '0);
  assign running     = (reload_i != '0);

  // a running timer at or below the delta reloads, others count down to zero
  always_comb begin
    step_o.expire = running && at_or_below;
    if (step_o.expire) begin
      step_o.remaining = reload_i;
    end else if (at_or_below) begin
      step_o.remaining = '0;
    end else begin
      step_o.remaining = diff[CNT_W-1:0];
    end
  end

endmodule

// File: hw/rtl/interval_timer_bank_unit.sv
// interval_timer_bank_unit: top level of the periodic timer bank with sticky
// expiry flags; depends on itb_pkg and itb_step_unit
//
//  port group        dir   handshake          payload
//  command           in    start_i / busy_o   opcode_i, timer_index_i, interval_value_i
//  result            out   done_o (strobe)    expired_o
//
// tick, start and stop finish without leaving idle: done_o pulses the cycle after the
// transfer and a new command can be taken in that same cycle.
// a query with pending ticks sweeps the bank through the single step unit, one
// timer per cycle, then replies from ST_REPLY; with no pending ticks it goes
// straight to ST_REPLY. busy_o is high meanwhile.
// reset clears all counts, intervals and flags at once; no clearing pass.
// done_o is a one-cycle strobe and the receiver cannot stall it.
module interval_timer_bank_unit import itb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       opcode_i,
  input  logic [7:0]       timer_index_i,
  input  logic [CNT_W-1:0] interval_value_i,
  output logic             done_o,
  output logic             expired_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_REPLY
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] cnt_q;
  logic [CNT_W-1:0] pend_q;
  logic [CNT_W-1:0] delta_q;
  logic [7:0]       idx_q;
  logic             done_q;
  logic             expired_q;

  logic [CNT_W-1:0] rem_q    [TIMER_COUNT];
  logic [CNT_W-1:0] reload_q [TIMER_COUNT];
  logic             flag_q   [TIMER_COUNT];

  logic       accept;
  logic       idx_ok;
  logic       qidx_ok;
  itb_step_t  step;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign idx_ok  = (timer_index_i < 8'(TIMER_COUNT));
  assign qidx_ok = (idx_q < 8'(TIMER_COUNT));

  // shared unit ages the timer under the sweep counter
  itb_step_unit u_step (
    .remaining_i (rem_q[cnt_q]),
    .reload_i    (reload_q[cnt_q]),
    .delta_i     (delta_q),
    .step_o      (step)
  );

  // sequencer, timer state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pend_q    <= '0;
      delta_q   <= '0;
      idx_q     <= '0;
      done_q    <= 1'b0;
      expired_q <= 1'b0;
      for (int t = 0; t < TIMER_COUNT; t++) begin
        rem_q[t]    <= '0;
        reload_q[t] <= '0;
        flag_q[t]   <= 1'b0;
      end
    end else begin
      done_q    <= 1'b0;
      expired_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (itb_op_e'(opcode_i))
              OP_TICK: begin
                if (pend_q != '1) begin
                  pend_q <= pend_q + CNT_W'(1);
                end
                done_q <= 1'b1;
              end
              OP_START: begin
                if (idx_ok) begin
                  flag_q[timer_index_i[IDX_W-1:0]]   <= 1'b0;
                  rem_q[timer_index_i[IDX_W-1:0]]    <= interval_value_i;
                  reload_q[timer_index_i[IDX_W-1:0]] <= interval_value_i;
                end
                done_q <= 1'b1;
              end
              OP_STOP: begin
                if (idx_ok) begin
                  reload_q[timer_index_i[IDX_W-1:0]] <= '0;
                end
                done_q <= 1'b1;
              end
              OP_QUERY: begin
                idx_q   <= timer_index_i;
                delta_q <= pend_q;
                pend_q  <= '0;
                cnt_q   <= '0;
                state_q <= (pend_q != '0) ? ST_SWEEP : ST_REPLY;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          rem_q[cnt_q] <= step.remaining;
          if (step.expire) begin
            flag_q[cnt_q] <= 1'b1;
          end
          if (cnt_q == IDX_W'(TIMER_COUNT - 1)) begin
            state_q <= ST_REPLY;
          end else begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        ST_REPLY: begin
          // read and clear the addressed sticky flag
          if (qidx_ok) begin
            expired_q                  <= flag_q[idx_q[IDX_W-1:0]];
            flag_q[idx_q[IDX_W-1:0]]   <= 1'b0;
          end
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign expired_o = expired_q;

  // checks on the sequencer
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  a_exp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expired_o |-> done_o) else $error("expired without result strobe");

  a_cmd_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i != OP_QUERY)) |=> done_o)
    else $error("non-query command did not answer next cycle");

  a_sweep_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (pend_q == '0))
    else $error("pending ticks not cleared during sweep");

  a_query_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_QUERY) && (pend_q == '0)) |=> ##1 done_o)
    else $error("query without pending ticks took too long");

endmodule
